// ===== design/tws_pkg.sv =====
// Package for the three-wheel speed PID block.
// Holds configuration types, register indexes and lane control types; no dependencies.
`default_nettype none
package tws_pkg;

  localparam int WHEELS    = 3;
  localparam int SPEED_W   = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int INTEG_W   = 18;
  localparam int GAIN_W    = 16;
  localparam int WINDOW_W  = 15;
  localparam int BOUND_W   = 16;
  localparam int DRIVE_W   = 28;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP_GAIN    = 3'd0,
    REG_KI_GAIN    = 3'd1,
    REG_KD_GAIN    = 3'd2,
    REG_INT_WINDOW = 3'd3,
    REG_INT_BOUND  = 3'd4
  } tws_reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp_gain;
    logic signed [GAIN_W-1:0] ki_gain;
    logic signed [GAIN_W-1:0] kd_gain;
    logic [WINDOW_W-1:0]      integration_window;
    logic [BOUND_W-1:0]       integral_bound;
  } tws_cfg_t;

  typedef struct packed {
    logic accept;
    logic load_s1;
    logic load_s2;
  } tws_ctrl_t;

endpackage
`default_nettype wire

// ===== design/tws_if.sv =====
// Channel interfaces for the three-wheel speed PID block.
// Depends on tws_pkg for field widths.
`default_nettype none
interface tws_in_if;
  import tws_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] target_0;
  logic signed [SPEED_W-1:0] target_1;
  logic signed [SPEED_W-1:0] target_2;
  logic signed [SPEED_W-1:0] measured_0;
  logic signed [SPEED_W-1:0] measured_1;
  logic signed [SPEED_W-1:0] measured_2;
  modport source (output valid, target_0, target_1, target_2,
                  measured_0, measured_1, measured_2, input ready);
  modport sink (input valid, target_0, target_1, target_2,
                measured_0, measured_1, measured_2, output ready);
endinterface

interface tws_out_if;
  import tws_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_0;
  logic signed [DRIVE_W-1:0] drive_1;
  logic signed [DRIVE_W-1:0] drive_2;
  modport source (output valid, drive_0, drive_1, drive_2, input ready);
  modport sink (input valid, drive_0, drive_1, drive_2, output ready);
endinterface

interface tws_cfg_if;
  import tws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/tws_cfg.sv =====
// Configuration register file for the three-wheel speed PID block.
// Depends on tws_pkg and tws_cfg_if.
`default_nettype none
module tws_cfg
  import tws_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  tws_cfg_if.sink    cfg_ch,
  output tws_cfg_t   cfg
);

  tws_cfg_t cfg_r;
  tws_cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_KP_GAIN:    cfg_nxt.kp_gain = cfg_ch.data;
        REG_KI_GAIN:    cfg_nxt.ki_gain = cfg_ch.data;
        REG_KD_GAIN:    cfg_nxt.kd_gain = cfg_ch.data;
        REG_INT_WINDOW: cfg_nxt.integration_window = cfg_ch.data[WINDOW_W-1:0];
        REG_INT_BOUND:  cfg_nxt.integral_bound = cfg_ch.data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain            <= 16'sd307;
      cfg_r.ki_gain            <= 16'sd26;
      cfg_r.kd_gain            <= 16'sd26;
      cfg_r.integration_window <= 15'd1000;
      cfg_r.integral_bound     <= 16'd300;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/tws_lane.sv =====
// One wheel's PID lane: state update at accept, error capture, products, drive sum.
// Depends on tws_pkg.
`default_nettype none
module tws_lane
  import tws_pkg::*;
#(
  parameter int FRAC_BITS = 8
)
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tws_ctrl_t                 ctrl,
  input  wire tws_cfg_t                  cfg,
  input  wire logic signed [SPEED_W-1:0] target,
  input  wire logic signed [SPEED_W-1:0] measured,
  output logic signed [DRIVE_W-1:0]      drive
);

  localparam int SUM_W  = 36;
  localparam int KP_P_W = GAIN_W + ERR_W;
  localparam int KD_P_W = GAIN_W + DIFF_W;
  localparam int KI_P_W = GAIN_W + INTEG_W;
  localparam int ACC_W  = INTEG_W + 1;

  logic signed [INTEG_W-1:0] integ_r;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [ERR_W-1:0]   last_err_r;
  logic                      int_en_r;

  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ERR_W-1:0]   meas_x;
  logic signed [ERR_W-1:0]   win_x;
  logic                      out_win;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   bound_x;

  logic signed [ERR_W-1:0]   err_s1_r;
  logic signed [DIFF_W-1:0]  diff_s1_r;
  logic signed [INTEG_W-1:0] integ_s1_r;

  logic signed [KP_P_W-1:0]  kp_p_r;
  logic signed [KD_P_W-1:0]  kd_p_r;
  logic signed [KI_P_W-1:0]  ki_p_r;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   sum_sh;

  always_comb begin
    err     = ERR_W'(target) - ERR_W'(measured);
    diff    = DIFF_W'(err) - DIFF_W'(last_err_r);
    meas_x  = ERR_W'(measured);
    win_x   = signed'({2'b00, cfg.integration_window});
    out_win = (meas_x > win_x) || (meas_x < -win_x);
    acc     = ACC_W'(integ_r) + ACC_W'(err);
    bound_x = signed'({3'b000, cfg.integral_bound});
    if (acc > bound_x) begin
      integ_nxt = bound_x[INTEG_W-1:0];
    end else if (acc < -bound_x) begin
      integ_nxt = INTEG_W'(-bound_x);
    end else begin
      integ_nxt = acc[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
      int_en_r   <= 1'b0;
    end else if (ctrl.accept) begin
      int_en_r   <= !out_win;
      last_err_r <= err;
      if (!out_win) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      err_s1_r   <= err;
      diff_s1_r  <= diff;
      integ_s1_r <= int_en_r ? integ_r : '0;
    end
    if (ctrl.load_s2) begin
      kp_p_r <= cfg.kp_gain * err_s1_r;
      kd_p_r <= cfg.kd_gain * diff_s1_r;
      ki_p_r <= cfg.ki_gain * integ_s1_r;
    end
  end

  always_comb begin
    sum    = SUM_W'(kp_p_r) + SUM_W'(kd_p_r) + SUM_W'(ki_p_r);
    sum_sh = sum >>> FRAC_BITS;
    drive  = sum_sh[DRIVE_W-1:0];
  end

endmodule
`default_nettype wire

// ===== design/three_wheel_speed_pid_top.sv =====
// Items pass the capture, product and output registers; the three wheel lanes run
// in parallel. Throughput: one item per cycle unless the output stalls; each lane's
// integral and last error are updated in the cycle the item is accepted.
// The output register merges the lane drives and decouples the result side.
// Reset (synchronous, active low) clears integrals, last errors, enable flags and
// pipeline valids, and loads the gain, window and bound registers with defaults.
`default_nettype none
module three_wheel_speed_pid_top
  import tws_pkg::*;
#(
  parameter int FRAC_BITS = 8
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  tws_in_if.sink    in_ch,
  tws_out_if.source out_ch,
  tws_cfg_if.sink   cfg_ch
);

  tws_cfg_t  cfg;
  tws_ctrl_t ctrl;

  logic v1_r;
  logic v2_r;
  logic out_valid_r;
  logic en_out;

  logic signed [SPEED_W-1:0] tgt  [WHEELS];
  logic signed [SPEED_W-1:0] meas [WHEELS];
  logic signed [DRIVE_W-1:0] lane_drive [WHEELS];
  logic signed [DRIVE_W-1:0] drive_r [WHEELS];

  tws_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign tgt[0]  = in_ch.target_0;
  assign tgt[1]  = in_ch.target_1;
  assign tgt[2]  = in_ch.target_2;
  assign meas[0] = in_ch.measured_0;
  assign meas[1] = in_ch.measured_1;
  assign meas[2] = in_ch.measured_2;

  always_comb begin
    en_out       = !out_valid_r || out_ch.ready;
    ctrl.load_s2 = !v2_r || en_out;
    ctrl.load_s1 = !v1_r || ctrl.load_s2;
    ctrl.accept  = in_ch.valid && ctrl.load_s1;
  end

  assign in_ch.ready = ctrl.load_s1;

  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    tws_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cfg      (cfg),
      .target   (tgt[w]),
      .measured (meas[w]),
      .drive    (lane_drive[w])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load_s1) begin
        v1_r <= in_ch.valid;
      end
      if (ctrl.load_s2) begin
        v2_r <= v1_r;
      end
      if (en_out) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      drive_r <= lane_drive;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive_0 = drive_r[0];
  assign out_ch.drive_1 = drive_r[1];
  assign out_ch.drive_2 = drive_r[2];

endmodule
`default_nettype wire
